>>> rtl/sha256_pkg.sv
// Shared constants, types and round functions for the SHA-256 hasher.
// Used by sha256_ctrl, sha256_dp and sha256_message_hasher.
`default_nettype none
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  // controller to datapath commands
  typedef struct packed {
    logic       put_byte;   // write data byte at current position, count it
    logic       put_pad;    // write 0x80 at current position
    logic       put_zero;   // write zero at position pad_pos
    logic [5:0] pad_pos;
    logic       put_len;    // write length words 14 and 15
    logic       init_vars;  // load a..h from hash values, start schedule
    logic       round;      // run one round
    logic       add_hash;   // fold a..h into hash values
    logic       restart;    // reload initial hash, clear count
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;        // byte position in block (count mod 64)
  } status_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_message_hasher.sv
// SHA-256 hasher top level: byte stream in, eight digest words out.
// After its 64th byte a full block is compressed (load, 64 rounds, fold);
//   a message end adds a padding sweep per padding block, each followed by
//   a compression, then the 8 digest words go out.
// Throughput: one byte per cycle between blocks; input stalls while a block
//   is padded, compressed on the single shared round unit, or its digest is output.
// Reset: asynchronous, active low; hash values reload, byte count clears.
`default_nettype none
module sha256_message_hasher (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         byte_present_i,
  input  wire         message_end_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_last_o
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;
  logic [5:0] rnd;
  logic [2:0] hidx;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .byte_present_i, .message_end_i,
    .out_valid_o, .out_stall_i, .word_index_o, .digest_last_o,
    .status_i(status), .cmd_o(cmd), .round_o(rnd), .hidx_o(hidx)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i, .round_i(rnd), .hidx_i(hidx),
    .status_o(status), .hash_o(digest_word_o)
  );

endmodule
`default_nettype wire

>>> rtl/sha256_dp.sv
// SHA-256 datapath: block buffer, message schedule window, round registers,
// hash values and byte count. Driven by sha256_ctrl; uses sha256_pkg.
`default_nettype none
module sha256_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire sha256_pkg::cmd_t        cmd_i,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic [5:0]              round_i,
  input  wire logic [2:0]              hidx_i,
  output sha256_pkg::status_t          status_o,
  output sha256_pkg::word_t            hash_o
);

  sha256_pkg::word_t blk_q [16];
  sha256_pkg::word_t w_q [16];     // schedule window, w_q[0] is w[t]
  sha256_pkg::word_t v_q [8];
  sha256_pkg::word_t h_q [8];
  logic [sha256_pkg::CountW-1:0] cnt_q;

  logic [5:0] wpos;
  logic [7:0] wbyte;
  logic       wen;
  sha256_pkg::word_t s0, s1, wnew, t1, t2, ch, maj;
  logic [63:0] bits;

  assign status_o.pos = cnt_q[5:0];
  assign hash_o = h_q[hidx_i];
  assign bits = {cnt_q, 3'b000};

  always_comb begin
    wen   = cmd_i.put_byte | cmd_i.put_pad | cmd_i.put_zero;
    wpos  = cmd_i.put_zero ? cmd_i.pad_pos : cnt_q[5:0];
    wbyte = cmd_i.put_byte ? data_byte_i : (cmd_i.put_pad ? 8'h80 : 8'h00);
    s0 = sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha256_pkg::ror(w_q[14], 17) ^ sha256_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = s1 + w_q[9] + s0 + w_q[0];
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + (sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
         ^ sha256_pkg::ror(v_q[4], 25)) + ch + sha256_pkg::round_k(round_i) + w_q[0];
    t2 = (sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
         ^ sha256_pkg::ror(v_q[0], 22)) + maj;
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      case (wpos[1:0])
        2'd0: blk_q[wpos[5:2]][31:24] <= wbyte;
        2'd1: blk_q[wpos[5:2]][23:16] <= wbyte;
        2'd2: blk_q[wpos[5:2]][15:8]  <= wbyte;
        default: blk_q[wpos[5:2]][7:0] <= wbyte;
      endcase
    end
    if (cmd_i.put_len) begin
      blk_q[14] <= bits[63:32];
      blk_q[15] <= bits[31:0];
    end
    if (cmd_i.init_vars) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
    end else begin
      if (cmd_i.restart) begin
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::init_hash(3'(i));
      end else begin
        if (cmd_i.put_byte) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.add_hash) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/sha256_ctrl.sv
// SHA-256 controller: input handshake, padding sequence, round counter and
// digest output. Commands sha256_dp; uses sha256_pkg.
`default_nettype none
module sha256_ctrl (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    byte_present_i,
  input  wire logic                    message_end_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [2:0]                   word_index_o,
  output logic                         digest_last_o,
  input  wire sha256_pkg::status_t     status_i,
  output sha256_pkg::cmd_t             cmd_o,
  output logic [5:0]                   round_o,
  output logic [2:0]                   hidx_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_INIT, S_ROUND, S_ADD, S_OUT
  } state_e;

  state_e     state_q;
  logic [5:0] rnd_q;
  logic [5:0] zpos_q;
  logic [2:0] widx_q;
  logic       fin_q;     // compressing the final block of a message
  logic       endp_q;    // 0x80 byte still to be written
  logic       more_q;    // padding continues after this block
  logic       lenblk_q;  // current padding block carries the length

  logic take;

  assign in_stall_o   = (state_q != S_IDLE);
  assign take         = in_valid_i & ~in_stall_o;
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = widx_q;
  assign digest_last_o = (widx_q == 3'd7);
  assign round_o      = rnd_q;
  assign hidx_o       = widx_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.pad_pos = zpos_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.put_byte = take & byte_present_i;
      end
      S_PAD: begin
        if (endp_q) begin
          cmd_o.put_pad = 1'b1;
        end else if (zpos_q == 6'd56 && lenblk_q) begin
          cmd_o.put_len = 1'b1;
        end else begin
          cmd_o.put_zero = 1'b1;
        end
      end
      S_INIT:  cmd_o.init_vars = 1'b1;
      S_ROUND: cmd_o.round = 1'b1;
      S_ADD:   cmd_o.add_hash = 1'b1;
      S_OUT:   cmd_o.restart = ~out_stall_i & (widx_q == 3'd7);
      default: cmd_o = '0;
    endcase
  end

  // The padding byte lands right after the last byte; the zero sweep then
  // runs up to 55 before the length, or up to 63 when an extra block is owed.
  logic [5:0] npos;
  assign npos = status_i.pos + (byte_present_i ? 6'd1 : 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rnd_q    <= '0;
      zpos_q   <= '0;
      widx_q   <= '0;
      fin_q    <= 1'b0;
      endp_q   <= 1'b0;
      more_q   <= 1'b0;
      lenblk_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (byte_present_i && status_i.pos == 6'd63) begin
              // block is full: compress first, pad afterwards if the message ends
              state_q <= S_INIT;
              fin_q   <= 1'b0;
              endp_q  <= message_end_i;
              more_q  <= message_end_i;
            end else if (message_end_i) begin
              state_q <= S_PAD;
              zpos_q  <= npos;
              endp_q  <= 1'b1;
              fin_q   <= 1'b0;
              more_q  <= 1'b0;
            end
          end
        end
        S_PAD: begin
          if (endp_q) begin
            endp_q   <= 1'b0;
            lenblk_q <= (zpos_q < 6'd56);
            if (zpos_q == 6'd63) begin
              state_q <= S_INIT;
              more_q  <= 1'b1;
            end else begin
              zpos_q <= zpos_q + 6'd1;
            end
          end else if (zpos_q == 6'd56 && lenblk_q) begin
            state_q <= S_INIT;
            fin_q   <= 1'b1;
          end else if (zpos_q == 6'd63) begin
            // no room for the length; compress and open a fresh block
            state_q <= S_INIT;
            more_q  <= 1'b1;
          end else begin
            zpos_q <= zpos_q + 6'd1;
          end
        end
        S_INIT: begin
          rnd_q   <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'(sha256_pkg::Rounds - 1)) state_q <= S_ADD;
        end
        S_ADD: begin
          if (fin_q) begin
            state_q <= S_OUT;
            widx_q  <= '0;
          end else if (more_q) begin
            state_q  <= S_PAD;
            more_q   <= 1'b0;
            zpos_q   <= '0;
            lenblk_q <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              state_q <= S_IDLE;
              fin_q   <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_when_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fin_q) else $error("digest shown outside final block");
  a_round_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |-> ($past(rnd_q) == 6'(sha256_pkg::Rounds - 1)))
    else $error("compression ended early");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !take) else $error("input taken while busy");
`endif

endmodule
`default_nettype wire

>>> dv/sha256_message_hasher_tb.sv
// Self-checking testbench for sha256_message_hasher: byte stream in, digest words out.
// Drives random and directed messages, predicts each digest with a local SHA-256
// model and compares every output word. Depends on rtl/sha256_message_hasher.sv.
`default_nettype none
module sha256_message_hasher_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  localparam int unsigned MaxCycles = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        message_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        digest_last_o;

  sha256_message_hasher DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  byte_item_t   pending_bytes[$];
  digest_item_t expected_words[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  items_sent = 0;
  int unsigned  messages_sent = 0;
  int unsigned  words_checked = 0;
  bit           quiet_phase = 1'b0;

  // Predictor state
  logic [31:0] hv[8];
  logic [31:0] blk[16];
  logic [60:0] msg_count;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] kconst(int i);
    logic [31:0] k[64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
          32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
          32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
          32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
          32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
          32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
          32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
          32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
          32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  task automatic restart_message();
    hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    msg_count = '0;
  endtask

  task automatic put_block_byte(int pos, logic [7:0] b);
    blk[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
  endtask

  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hv;
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endtask

  task automatic predict_digest(byte_item_t it);
    int pos;
    logic [63:0] bits;
    if (it.present) begin
      pos = int'(msg_count[5:0]);
      put_block_byte(pos, it.data);
      msg_count++;
      if (pos == 63) compress_block();
    end
    if (!it.last) return;
    pos = int'(msg_count[5:0]);
    put_block_byte(pos, 8'h80);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        put_block_byte(pos, 8'h00);
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      put_block_byte(pos, 8'h00);
      pos++;
    end
    bits = {msg_count, 3'b000};
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_block();
    for (int i = 0; i < 8; i++)
      expected_words.push_back('{word: hv[i], index: 3'(i), last: (i == 7)});
    restart_message();
  endtask

  task automatic queue_message(int len, bit end_empty);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data = 8'($urandom_range(0, 255));
      it.present = 1'b1;
      it.last = !end_empty && (i == len - 1);
      pending_bytes.push_back(it);
      // sprinkle ignored items
      if ($urandom_range(0, 19) == 0) begin
        it.present = 1'b0;
        it.last = 1'b0;
        pending_bytes.push_back(it);
      end
    end
    if (end_empty || len == 0) begin
      it.data = 8'($urandom_range(0, 255));
      it.present = 1'b0;
      it.last = 1'b1;
      pending_bytes.push_back(it);
    end
  endtask

  // Driver: hold payload while stalled, advance on transfer
  always @(posedge clk_i) begin
    byte_item_t it;
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) begin
          predict_digest({data_byte_i, byte_present_i, message_end_i});
          bytes_sent += byte_present_i;
          messages_sent += message_end_i;
          items_sent++;
        end
        if (pending_bytes.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 11)) begin
          it = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= it.data;
          byte_present_i <= it.present;
          message_end_i <= it.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet_phase && ($urandom_range(0, 99) < 11);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    digest_item_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest word %h", digest_word_o);
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (digest_word_o !== exp_w.word) begin
          $error("digest_word expected %h actual %h", exp_w.word, digest_word_o);
          error_count++;
        end
        if (word_index_o !== exp_w.index) begin
          $error("word_index expected %0d actual %0d", exp_w.index, word_index_o);
          error_count++;
        end
        if (digest_last_o !== exp_w.last) begin
          $error("digest_last expected %0d actual %0d", exp_w.last, digest_last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MaxCycles) begin
      $display("[sha256_message_hasher] ERROR");
      $finish;
    end
  end

  initial begin
    int lens[$];
    restart_message();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    // Directed: empty message, then lengths around the padding boundaries
    queue_message(0, 1'b1);
    lens = '{1, 55, 56, 63};
    foreach (lens[i]) queue_message(lens[i], 1'(i % 2));
    // Extreme byte values with both flags explicit
    pending_bytes.push_back('{data: 8'hff, present: 1'b1, last: 1'b0});
    pending_bytes.push_back('{data: 8'h00, present: 1'b0, last: 1'b0});
    pending_bytes.push_back('{data: 8'h00, present: 1'b1, last: 1'b1});
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_bytes.size() == 0);
    // A full one-block message with no idling on either side
    quiet_phase = 1'b1;
    queue_message(64, 1'b0);
    wait (pending_bytes.size() == 0);
    quiet_phase = 1'b0;
    // Random: mostly short messages, the odd multi-block one
    while (items_sent < 270) begin
      queue_message(($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                                : $urandom_range(0, 20),
                    $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) quiet_phase = !quiet_phase;
      wait (pending_bytes.size() == 0);
    end
    quiet_phase = 1'b0;
    wait (!in_valid_i && expected_words.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Hashed %0d messages, %0d bytes; checked %0d digest words.",
             messages_sent, bytes_sent, words_checked);
    if (error_count == 0 && expected_words.size() == 0)
      $display("[sha256_message_hasher] OK");
    else
      $display("[sha256_message_hasher] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/sha256_pkg.sv
rtl/sha256_dp.sv
rtl/sha256_ctrl.sv
rtl/sha256_message_hasher.sv
dv/sha256_message_hasher_tb.sv
